### src/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) else $error("assertion failed");
`endif

### src/tmbl_pkg.sv
// ----------------------------------------------------------------------------
// Temporal median package
// Shared types and constants for the byte lane temporal median block.
// ----------------------------------------------------------------------------
package tmbl_pkg;
    localparam int unsigned WordW  = 32;
    localparam int unsigned PosW   = 12;
    localparam int unsigned CntW   = 5;
    localparam int unsigned LaneW  = 8;
    localparam int unsigned Lanes  = 4;
    localparam logic [CntW-1:0] NumSamplesReset = 5'd5;

    typedef struct packed {
        logic [WordW-1:0] pixel_word;
        logic [PosW-1:0]  pixel_position;
        logic             last_of_frame;
    } t_in_req;

    typedef struct packed {
        logic [WordW-1:0] median_word;
        logic [PosW-1:0]  out_position;
    } t_out_req;

    // Control from the sequencer to the lanes.
    typedef struct packed {
        logic start;
        logic step;
    } t_lane_ctl;
endpackage

### src/tmbl_if.sv
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid and ready channels carrying input and result requests.
// ----------------------------------------------------------------------------
interface tmbl_in_if;
    import tmbl_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tmbl_out_if;
    import tmbl_pkg::*;
    logic     valid;
    logic     ready;
    t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/tmbl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tmbl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/tmbl_lane.sv
// ----------------------------------------------------------------------------
// Median lane
// Counts, for each of the candidate samples, how many samples are smaller
// or equal with lower index; the candidate whose rank is the median wins.
// Samples arrive one per step and are compared against a held row.
// ----------------------------------------------------------------------------
module tmbl_lane #(
    parameter int unsigned MAX_FRAMES = 25
) (
    input  logic                     i_clk,
    input  tmbl_pkg::t_lane_ctl      i_ctl,
    input  logic [MAX_FRAMES*8-1:0]  i_row,
    input  logic [$clog2(MAX_FRAMES+1)-1:0] i_idx,
    input  logic [$clog2(MAX_FRAMES+1)-1:0] i_med,
    input  logic [$clog2(MAX_FRAMES+1)-1:0] i_n,
    output logic [7:0]               o_median
);
    import tmbl_pkg::*;
    localparam int unsigned IW = $clog2(MAX_FRAMES + 1);

    logic [IW-1:0] r_rank [MAX_FRAMES];
    logic [7:0]    w_s;
    logic [7:0]    w_c [MAX_FRAMES];
    logic [7:0]    w_med;

    always_comb begin
        w_s = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            w_c[k] = i_row[k*8 +: 8];
            if (i_idx == IW'(k)) begin
                w_s = i_row[k*8 +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (i_ctl.start) begin
                r_rank[k] <= '0;
            end else if (i_ctl.step) begin
                if ((w_s < w_c[k]) || ((w_s == w_c[k]) && (i_idx < IW'(k)))) begin
                    r_rank[k] <= r_rank[k] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_med = '0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if ((IW'(k) < i_n) && (r_rank[k] == i_med)) begin
                w_med = w_c[k];
            end
        end
    end

    assign o_median = w_med;
endmodule

### src/temporal_median_byte_lanes_core.sv
// ----------------------------------------------------------------------------
// Temporal median over byte lanes
// Channel  | Dir | Payload
// s_in     | in  | pixel_word, pixel_position, last_of_frame
// m_out    | out | median_word, out_position
// cfg      | in  | frame count, write enable and data
// An item passes the accept state, one row read, one row write-back, N rank steps
// over the four lanes, N the effective count, and one merge state, in which the
// result waits until it is taken.
// After reset a clearing pass over all FRAME_WORDS rows zeroes the history
// memory; no request is taken meanwhile. A stalled result holds the block.
// ----------------------------------------------------------------------------
module temporal_median_byte_lanes_core #(
    parameter int unsigned MAX_FRAMES  = 25,
    parameter int unsigned FRAME_WORDS = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    tmbl_in_if.sink    s_in,
    tmbl_out_if.source m_out
);
    import tmbl_pkg::*;
    localparam int unsigned IW = $clog2(MAX_FRAMES + 1);
    localparam int unsigned AW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int unsigned RW = MAX_FRAMES * WordW;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001, ST_IDLE = 6'b000010, ST_READ = 6'b000100,
        ST_WRITE = 6'b001000, ST_RANK = 6'b010000, ST_OUT = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cfg;
    logic [IW-1:0]   r_slot, r_idx, w_n, w_sl;
    logic [AW-1:0]   r_clr, w_addr;
    t_in_req         r_req;
    logic [RW-1:0]   r_row, w_rdata, w_wdata;
    logic [WordW-1:0] w_med;
    t_lane_ctl       w_ctl;
    logic            w_we;

    always_comb begin
        if (r_cfg == '0) begin
            w_n = IW'(1);
        end else if (32'(r_cfg) > MAX_FRAMES) begin
            w_n = IW'(MAX_FRAMES);
        end else begin
            w_n = IW'(r_cfg);
        end
        w_sl = (r_slot < w_n) ? r_slot : '0;
    end

    // Row index: position modulo frame size, by reciprocal product below 2**PosW words.
    if (FRAME_WORDS >= (1 << PosW)) begin : g_addr
        assign w_addr = AW'(r_req.pixel_position);
    end else if (FRAME_WORDS > 1) begin : g_addr_mod
        localparam logic [23:0] Recip = 24'(((1 << 24) + FRAME_WORDS - 1) / FRAME_WORDS);
        logic [35:0] w_prod;
        logic [23:0] w_sub;
        assign w_prod = 36'(r_req.pixel_position) * 36'(Recip);
        assign w_sub  = 24'(w_prod[35:24]) * 24'(FRAME_WORDS);
        assign w_addr = AW'(24'(r_req.pixel_position) - w_sub);
    end else begin : g_addr1
        assign w_addr = '0;
    end

    always_comb begin
        w_wdata = w_rdata;
        w_wdata[w_sl*WordW +: WordW] = r_req.pixel_word;
    end

    assign w_we = (r_state == ST_CLEAR) || (r_state == ST_WRITE);

    tmbl_ram #(.WIDTH(RW), .DEPTH((FRAME_WORDS > 1) ? FRAME_WORDS : 2)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ((r_state == ST_CLEAR) ? r_clr : w_addr),
        .i_wdata ((r_state == ST_CLEAR) ? '0 : w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_ctl.start = (r_state == ST_WRITE);
    assign w_ctl.step  = (r_state == ST_RANK);

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
        logic [MAX_FRAMES*8-1:0] w_lrow;
        for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_k
            assign w_lrow[k*8 +: 8] = r_row[k*WordW + l*8 +: 8];
        end
        tmbl_lane #(.MAX_FRAMES(MAX_FRAMES)) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_row    (w_lrow),
            .i_idx    (r_idx),
            .i_med    ((w_n - 1'b1) >> 1),
            .i_n      (w_n),
            .o_median (w_med[l*8 +: 8])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (32'(r_clr) == FRAME_WORDS - 1) n_state = ST_IDLE;
            ST_IDLE:  if (s_in.valid) n_state = ST_READ;
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_RANK;
            ST_RANK:  if (r_idx == w_n - 1'b1) n_state = ST_OUT;
            ST_OUT:   if (m_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cfg   <= NumSamplesReset;
            r_slot  <= '0;
            r_clr   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_WRITE) begin
                r_idx <= '0;
                if (r_req.last_of_frame) begin
                    r_slot <= (w_sl + 1'b1 >= w_n) ? '0 : w_sl + 1'b1;
                end else begin
                    r_slot <= w_sl;
                end
            end else if (r_state == ST_RANK) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) r_req <= s_in.data;
        if (r_state == ST_WRITE) r_row <= w_wdata;
    end

    assign s_in.ready             = (r_state == ST_IDLE);
    assign m_out.valid            = (r_state == ST_OUT);
    assign m_out.data.median_word = w_med;
    assign m_out.data.out_position = r_req.pixel_position;
endmodule

### src/tmbl_checker.sv
// ----------------------------------------------------------------------------
// Temporal median checker
// Port level checks on the handshake and ordering of requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module tmbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_out_pos
);
    `ASSERT_IMPL(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid)
    `ASSERT_IMPL(a_pos, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> $stable(i_out_pos))
    `ASSERT_IMPL(a_excl, i_clk, i_rst_n, !(i_in_ready && i_out_valid))
    `ASSERT_IMPL(a_gap, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_out_valid)
    `ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind temporal_median_byte_lanes_core tmbl_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (s_in.valid),
    .i_in_ready  (s_in.ready),
    .i_out_valid (m_out.valid),
    .i_out_ready (m_out.ready),
    .i_out_pos   (m_out.data.out_position)
);
